// ----- hw/rtl/sne_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sne_pkg
// Types, codes and defaults shared by the sorted note event table.
// ----------------------------------------------------------------------------
package sne_pkg;

    // default table depth
    localparam int DEPTH_DEF = 64;

    // operation codes
    localparam logic FUNC_INSERT      = 1'b0;
    localparam logic FUNC_FIND        = 1'b1;

    // find modes
    localparam logic MODE_PITCH_STAMP = 1'b0;

    // result status codes
    localparam logic STATUS_DONE      = 1'b0;
    localparam logic STATUS_FULL      = 1'b1;

    // input item
    typedef struct packed {
        logic        func;
        logic        match_mode;
        logic [6:0]  pitch;
        logic [31:0] stamp;
        logic [7:0]  tag;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        status;
        logic        found;
        logic [5:0]  position;
        logic [6:0]  found_pitch;
        logic [31:0] found_stamp;
        logic [7:0]  found_tag;
    } t_out_item;

    // one stored table entry
    typedef struct packed {
        logic [6:0]  pitch;
        logic [31:0] stamp;
        logic [7:0]  tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // walk sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_FIND,
        S_DONE
    } t_walk_state;

    // result hand-over from the walk sequencer to the output stage
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res_xfer;

endpackage
`default_nettype wire

// ----- hw/rtl/sne_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sne_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sne_walk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sne_walk
// Entry count, walk sequencer and table RAM. Inserts walk from the tail
// towards the head shifting entries down; finds walk from the head.
// ----------------------------------------------------------------------------
module sne_walk #(
    parameter int DEPTH = sne_pkg::DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sne_pkg::t_in_item i_in_item,
    output sne_pkg::t_res_xfer     o_res,
    input  wire logic              i_res_take
);
    import sne_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (AW > 6) ? AW : 6;

    t_walk_state     r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_pend_idx, n_pend_idx;
    t_in_item        r_op, n_op;
    t_out_item       r_res, n_res;

    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    t_entry          ram_wr_data;
    logic [AW-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_raw;
    t_entry          rd_entry;
    t_entry          new_entry;
    logic [AW-1:0]   last_idx;
    logic [IW-1:0]   pos_wide;

    sne_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_raw)
    );

    assign rd_entry  = t_entry'(ram_rd_raw);
    assign new_entry = '{pitch: r_op.pitch, stamp: r_op.stamp, tag: r_op.tag};
    assign last_idx  = AW'(r_count - CW'(1));
    assign pos_wide  = IW'(r_pend_idx);

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_op       <= n_op;
        r_res      <= n_res;
    end

    // next state, RAM addressing and result build
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_op        = r_op;
        n_res       = r_res;
        ram_wr_en   = 1'b0;
        ram_wr_addr = AW'(r_pend_idx + AW'(1));
        ram_wr_data = rd_entry;
        ram_rd_addr = AW'(r_pend_idx - AW'(1));

        unique case (r_state)
            S_IDLE: begin
                // start reading the tail for an insert, the head for a find
                ram_rd_addr = (i_in_item.func == FUNC_INSERT) ? last_idx : '0;
                if (i_in_valid) begin
                    n_op  = i_in_item;
                    n_res = '0;
                    if (i_in_item.func == FUNC_INSERT) begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_res.status = STATUS_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_pend     = (r_count != '0);
                            n_pend_idx = last_idx;
                            n_state    = S_INS;
                        end
                    end else begin
                        if (i_in_item.match_mode != MODE_PITCH_STAMP || r_count == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_pend     = 1'b1;
                            n_pend_idx = '0;
                            n_state    = S_FIND;
                        end
                    end
                end
            end
            S_INS: begin
                ram_wr_en = 1'b1;
                if (r_pend) begin
                    if (rd_entry.pitch > r_op.pitch) begin
                        // new entry lands just below a higher pitch
                        ram_wr_data = new_entry;
                        n_pend      = 1'b0;
                        n_count     = CW'(r_count + CW'(1));
                        n_state     = S_DONE;
                    end else if (r_pend_idx == '0) begin
                        // head shifted down, new entry goes to the head next
                        n_pend = 1'b0;
                    end else begin
                        n_pend_idx = AW'(r_pend_idx - AW'(1));
                    end
                end else begin
                    ram_wr_addr = '0;
                    ram_wr_data = new_entry;
                    n_count     = CW'(r_count + CW'(1));
                    n_state     = S_DONE;
                end
            end
            S_FIND: begin
                ram_rd_addr = AW'(r_pend_idx + AW'(1));
                if (rd_entry.pitch == r_op.pitch && rd_entry.stamp == r_op.stamp) begin
                    n_res.found       = 1'b1;
                    n_res.position    = pos_wide[5:0];
                    n_res.found_pitch = rd_entry.pitch;
                    n_res.found_stamp = rd_entry.stamp;
                    n_res.found_tag   = rd_entry.tag;
                    n_pend            = 1'b0;
                    n_state           = S_DONE;
                end else if (r_pend_idx == last_idx) begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_pend_idx = AW'(r_pend_idx + AW'(1));
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.item  = r_res;

    // count never runs past the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // count only ever grows by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count))
            |-> r_count == CW'($past(r_count) + CW'(1)))
        else $error("entry count changed by other than one");

    // a find never writes the table
    a_find_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> !ram_wr_en)
        else $error("table write during find");

    // a completed insert that was not dropped bumps the count
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS && !r_pend) |=> r_count == CW'($past(r_count) + CW'(1)))
        else $error("insert finished without count update");

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_note_event_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_note_event_table
// Table of note events in descending pitch order with insert and find.
// ----------------------------------------------------------------------------
// Walk: an insert shifts down each entry at or below its pitch, then writes
//   the new entry; a find reads from the head up to the match or the last entry;
//   a dropped insert, a find on an empty table or in an unsupported mode skip it.
// Throughput: one item per walk; the walk moves one entry per cycle.
// Reset: clears the entry count, the walk state and the output valid flag; RAM
//   contents are left as they are and are never read before being written.
module sorted_note_event_table #(
    parameter int DEPTH = sne_pkg::DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire sne_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output sne_pkg::t_out_item      o_out_item
);
    import sne_pkg::*;

    t_res_xfer res;
    logic      res_take;
    logic      r_out_valid;
    t_out_item r_out_item;

    sne_walk #(
        .DEPTH (DEPTH)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_res      (res),
        .i_res_take (res_take)
    );

    // output register loads when empty or being drained
    assign res_take = res.valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_item <= res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire
